>>> sv/aisr_pkg.sv
// Shared types, widths and saturation helper for the inverse scaled rotation block.
package aisr_pkg;

  localparam int WORD_W   = 32;
  localparam int LEN_W    = 64;
  localparam int QUOT_W   = 32;
  localparam int FRAC_DEF = 16;
  localparam int FRAC_MAX = 24;
  localparam int NUM_W    = LEN_W + 2 * FRAC_MAX;
  localparam int LANES    = 4;
  localparam int AXES     = 3;
  localparam int SHIFT_LANE = 3;

  localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] axis0_x;
    logic signed [WORD_W-1:0] axis0_y;
    logic signed [WORD_W-1:0] axis0_z;
    logic signed [WORD_W-1:0] axis1_x;
    logic signed [WORD_W-1:0] axis1_y;
    logic signed [WORD_W-1:0] axis1_z;
    logic signed [WORD_W-1:0] axis2_x;
    logic signed [WORD_W-1:0] axis2_y;
    logic signed [WORD_W-1:0] axis2_z;
    logic signed [WORD_W-1:0] shift_x;
    logic signed [WORD_W-1:0] shift_y;
    logic signed [WORD_W-1:0] shift_z;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] inv_row0_x;
    logic signed [WORD_W-1:0] inv_row0_y;
    logic signed [WORD_W-1:0] inv_row0_z;
    logic signed [WORD_W-1:0] inv_row1_x;
    logic signed [WORD_W-1:0] inv_row1_y;
    logic signed [WORD_W-1:0] inv_row1_z;
    logic signed [WORD_W-1:0] inv_row2_x;
    logic signed [WORD_W-1:0] inv_row2_y;
    logic signed [WORD_W-1:0] inv_row2_z;
    logic signed [WORD_W-1:0] inv_shift_x;
    logic signed [WORD_W-1:0] inv_shift_y;
    logic signed [WORD_W-1:0] inv_shift_z;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]                den;
    logic [LANES-1:0][NUM_W-1:0]     num;
    logic [LANES-1:0]                neg;
    logic                            zero;
  } job_t;

  typedef struct packed {
    logic [LEN_W-1:0]                den;
    logic [LANES-1:0][LEN_W-1:0]     rem;
    logic [LANES-1:0][QUOT_W-1:0]    quo;
    logic [LANES-1:0]                ovf;
    logic [LANES-1:0]                neg;
    logic                            zero;
  } div_stage_t;

  typedef struct packed {
    logic [LANES-1:0][QUOT_W-1:0]    quo;
    logic [LANES-1:0]                rnd;
    logic [LANES-1:0]                ovf;
    logic [LANES-1:0]                neg;
    logic                            zero;
  } div_res_t;

  function automatic word_t pack_word(logic neg, logic ovf, logic [QUOT_W:0] mag);
    if (ovf) begin
      return neg ? NEG_LIMIT : POS_LIMIT;
    end
    if (!neg) begin
      return (mag > {1'b0, POS_LIMIT}) ? POS_LIMIT : mag[WORD_W-1:0];
    end
    if (mag >= {1'b0, NEG_LIMIT}) begin
      return NEG_LIMIT;
    end
    return word_t'(~mag[WORD_W-1:0] + word_t'(1));
  endfunction

endpackage

>>> sv/aisr_if.sv
// Handshake channels for input and result items.
interface aisr_in_if;
  logic                 valid;
  logic                 ready;
  aisr_pkg::in_item_t   data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface aisr_out_if;
  logic                 valid;
  logic                 ready;
  aisr_pkg::out_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> sv/affine_inverse_scaled_rotation.sv
// Top level: inverse of an affine transform with orthogonal scaled axes.
//
//   channel  | dir | handshake    | payload
//   in_ch    | in  | valid/ready  | three axis columns and translation, Q16.16
//   out_ch   | out | valid/ready  | inverse rows and inverse translation, saturated
//
// One item per cycle sustained while out_ch is ready.
// Pipeline: four front stages, the divider entry stage, the 32-stage divider with
// one quotient bit per stage, and the output register.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
// A stall at out_ch freezes the whole pipeline; in_ch.ready drops in the same cycle.
module affine_inverse_scaled_rotation #(
  parameter int FRAC_BITS = aisr_pkg::FRAC_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  aisr_in_if.sink           in_ch,
  aisr_out_if.source        out_ch
);

  localparam int A  = aisr_pkg::AXES;
  localparam int Q  = aisr_pkg::QUOT_W;
  localparam int SL = aisr_pkg::SHIFT_LANE;

  logic                                adv;
  logic                                job_valid;
  aisr_pkg::job_t [A-1:0]              job;
  logic [A-1:0]                        dv;
  aisr_pkg::div_res_t [A-1:0]          dres;
  aisr_pkg::word_t [A-1:0][SL:0]       word_nxt;
  aisr_pkg::out_item_t                 out_nxt;
  aisr_pkg::out_item_t                 out_r;
  logic                                out_valid_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;

  aisr_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_ch.valid),
    .in_data   (in_ch.data),
    .job_valid (job_valid),
    .job       (job)
  );

  for (genvar i = 0; i < A; i++) begin : g_axis
    aisr_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .job_valid (job_valid),
      .job       (job[i]),
      .res_valid (dv[i]),
      .res       (dres[i])
    );
  end

  always_comb begin
    logic [Q:0] mag;
    for (int i = 0; i < A; i++) begin
      for (int l = 0; l <= SL; l++) begin
        mag = {1'b0, dres[i].quo[l]} + (Q+1)'(dres[i].rnd[l]);
        word_nxt[i][l] = dres[i].zero ? aisr_pkg::POS_LIMIT
                       : aisr_pkg::pack_word(dres[i].neg[l], dres[i].ovf[l], mag);
      end
    end
    out_nxt.inv_row0_x  = word_nxt[0][0];
    out_nxt.inv_row0_y  = word_nxt[0][1];
    out_nxt.inv_row0_z  = word_nxt[0][2];
    out_nxt.inv_row1_x  = word_nxt[1][0];
    out_nxt.inv_row1_y  = word_nxt[1][1];
    out_nxt.inv_row1_z  = word_nxt[1][2];
    out_nxt.inv_row2_x  = word_nxt[2][0];
    out_nxt.inv_row2_y  = word_nxt[2][1];
    out_nxt.inv_row2_z  = word_nxt[2][2];
    out_nxt.inv_shift_x = word_nxt[0][SL];
    out_nxt.inv_shift_y = word_nxt[1][SL];
    out_nxt.inv_shift_z = word_nxt[2][SL];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= &dv;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    (dv[0] == dv[1]) && (dv[1] == dv[2]))
    else $error("divider valid bits disagree");

  a_zero_axis: assert property (@(posedge clk) disable iff (!rst_n)
    dv[0] && dres[0].zero |-> (word_nxt[0][0] == aisr_pkg::POS_LIMIT)
                           && (word_nxt[0][SL] == aisr_pkg::POS_LIMIT))
    else $error("zero-length axis not saturated");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    dv[1] && !dres[1].zero && dres[1].ovf[SL] |->
      (word_nxt[1][SL] == aisr_pkg::POS_LIMIT) || (word_nxt[1][SL] == aisr_pkg::NEG_LIMIT))
    else $error("overflowed quotient not saturated");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule

>>> sv/aisr_front.sv
// Front pipeline: magnitudes, products, sums and division operands per axis.
module aisr_front #(
  parameter int FRAC_BITS = aisr_pkg::FRAC_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    adv,
  input  logic                                    in_valid,
  input  aisr_pkg::in_item_t                      in_data,
  output logic                                    job_valid,
  output aisr_pkg::job_t [aisr_pkg::AXES-1:0]     job
);

  localparam int W = aisr_pkg::WORD_W;
  localparam int L = aisr_pkg::LEN_W;
  localparam int N = aisr_pkg::NUM_W;
  localparam int A = aisr_pkg::AXES;

  logic [W-1:0] aw [A][A];
  logic [W-1:0] tw [A];

  logic [W-1:0] am_nxt [A][A];
  logic         an_nxt [A][A];
  logic [W-1:0] tm_nxt [A];
  logic         tn_nxt [A];

  logic [W-1:0] am1_r [A][A];
  logic         an1_r [A][A];
  logic [W-1:0] tm1_r [A];
  logic         tn1_r [A];
  logic         v1_r;

  logic [L-1:0] sq2_r [A][A];
  logic [L-1:0] pt2_r [A][A];
  logic         sd2_r [A][A];
  logic [W-1:0] am2_r [A][A];
  logic         an2_r [A][A];
  logic         v2_r;

  logic [L-1:0] len_nxt [A];
  logic [L-1:0] pos_nxt [A];
  logic [L-1:0] neg_nxt [A];
  logic [L-1:0] len3_r [A];
  logic [L-1:0] pos3_r [A];
  logic [L-1:0] neg3_r [A];
  logic [W-1:0] am3_r [A][A];
  logic         an3_r [A][A];
  logic         v3_r;

  aisr_pkg::job_t [A-1:0] job_nxt;
  aisr_pkg::job_t [A-1:0] job_r;
  logic                   v4_r;

  assign aw[0][0] = in_data.axis0_x;
  assign aw[0][1] = in_data.axis0_y;
  assign aw[0][2] = in_data.axis0_z;
  assign aw[1][0] = in_data.axis1_x;
  assign aw[1][1] = in_data.axis1_y;
  assign aw[1][2] = in_data.axis1_z;
  assign aw[2][0] = in_data.axis2_x;
  assign aw[2][1] = in_data.axis2_y;
  assign aw[2][2] = in_data.axis2_z;
  assign tw[0]    = in_data.shift_x;
  assign tw[1]    = in_data.shift_y;
  assign tw[2]    = in_data.shift_z;

  always_comb begin
    for (int i = 0; i < A; i++) begin
      tn_nxt[i] = tw[i][W-1];
      tm_nxt[i] = tw[i][W-1] ? (~tw[i] + W'(1)) : tw[i];
      for (int j = 0; j < A; j++) begin
        an_nxt[i][j] = aw[i][j][W-1];
        am_nxt[i][j] = aw[i][j][W-1] ? (~aw[i][j] + W'(1)) : aw[i][j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < A; i++) begin
      len_nxt[i] = sq2_r[i][0] + sq2_r[i][1] + sq2_r[i][2];
      pos_nxt[i] = (sd2_r[i][0] ? L'(0) : pt2_r[i][0]) + (sd2_r[i][1] ? L'(0) : pt2_r[i][1])
                 + (sd2_r[i][2] ? L'(0) : pt2_r[i][2]);
      neg_nxt[i] = (sd2_r[i][0] ? pt2_r[i][0] : L'(0)) + (sd2_r[i][1] ? pt2_r[i][1] : L'(0))
                 + (sd2_r[i][2] ? pt2_r[i][2] : L'(0));
    end
  end

  always_comb begin
    logic         dneg;
    logic [L-1:0] dmag;
    job_nxt = '0;
    for (int i = 0; i < A; i++) begin
      dneg = neg3_r[i] > pos3_r[i];
      dmag = dneg ? (neg3_r[i] - pos3_r[i]) : (pos3_r[i] - neg3_r[i]);
      job_nxt[i].den  = len3_r[i];
      job_nxt[i].zero = (len3_r[i] == '0);
      for (int j = 0; j < A; j++) begin
        job_nxt[i].num[j] = {{(N-W){1'b0}}, am3_r[i][j]} << (2 * FRAC_BITS);
        job_nxt[i].neg[j] = an3_r[i][j];
      end
      job_nxt[i].num[aisr_pkg::SHIFT_LANE] = {{(N-L){1'b0}}, dmag} << FRAC_BITS;
      job_nxt[i].neg[aisr_pkg::SHIFT_LANE] = !dneg;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      am1_r <= am_nxt;
      an1_r <= an_nxt;
      tm1_r <= tm_nxt;
      tn1_r <= tn_nxt;
      for (int i = 0; i < A; i++) begin
        for (int j = 0; j < A; j++) begin
          sq2_r[i][j] <= am1_r[i][j] * am1_r[i][j];
          pt2_r[i][j] <= am1_r[i][j] * tm1_r[j];
          sd2_r[i][j] <= an1_r[i][j] ^ tn1_r[j];
        end
      end
      am2_r  <= am1_r;
      an2_r  <= an1_r;
      len3_r <= len_nxt;
      pos3_r <= pos_nxt;
      neg3_r <= neg_nxt;
      am3_r  <= am2_r;
      an3_r  <= an2_r;
      job_r  <= job_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign job_valid = v4_r;
  assign job       = job_r;

endmodule

>>> sv/aisr_div.sv
// Pipelined restoring divider: one quotient bit per stage, four numerators over one length.
module aisr_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 job_valid,
  input  aisr_pkg::job_t       job,
  output logic                 res_valid,
  output aisr_pkg::div_res_t   res
);

  localparam int L  = aisr_pkg::LEN_W;
  localparam int Q  = aisr_pkg::QUOT_W;
  localparam int N  = aisr_pkg::NUM_W;
  localparam int NL = aisr_pkg::LANES;

  aisr_pkg::div_stage_t st_r   [Q+1];
  aisr_pkg::div_stage_t st_nxt [Q+1];
  logic                 v_r    [Q+1];

  always_comb begin
    logic [N-Q-1:0] top;
    st_nxt[0]      = '0;
    st_nxt[0].den  = job.den;
    st_nxt[0].neg  = job.neg;
    st_nxt[0].zero = job.zero;
    for (int l = 0; l < NL; l++) begin
      top = job.num[l][N-1:Q];
      st_nxt[0].ovf[l] = top >= {{(N-Q-L){1'b0}}, job.den};
      st_nxt[0].rem[l] = top[L-1:0];
      st_nxt[0].quo[l] = job.num[l][Q-1:0];
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_step
    always_comb begin
      logic [L:0] trial;
      logic [L:0] diff;
      logic       ge;
      st_nxt[k+1] = st_r[k];
      for (int l = 0; l < NL; l++) begin
        trial = {st_r[k].rem[l], st_r[k].quo[l][Q-1]};
        diff  = trial - {1'b0, st_r[k].den};
        ge    = trial >= {1'b0, st_r[k].den};
        st_nxt[k+1].rem[l] = ge ? diff[L-1:0] : trial[L-1:0];
        st_nxt[k+1].quo[l] = {st_r[k].quo[l][Q-2:0], ge};
      end
    end
  end

  for (genvar k = 0; k <= Q; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (adv) begin
          v_r[k] <= job_valid;
        end
      end
    end else begin : g_vk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (adv) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_comb begin
    res      = '0;
    res.quo  = st_r[Q].quo;
    res.ovf  = st_r[Q].ovf;
    res.neg  = st_r[Q].neg;
    res.zero = st_r[Q].zero;
    for (int l = 0; l < NL; l++) begin
      res.rnd[l] = {st_r[Q].rem[l], 1'b0} >= {1'b0, st_r[Q].den};
    end
  end

  assign res_valid = v_r[Q];

endmodule

>>> bench/aisr_scoreboard.sv
// Checker for the inverse scaled rotation block: predicts each result and compares it.
`timescale 1ns / 1ps
module aisr_scoreboard (
  input  logic     clk,
  input  logic     rst_n,
  aisr_in_if       in_ch,
  aisr_out_if      out_ch,
  output int       fail_count,
  output int       pending,
  output int       results_seen,
  output int       saturated_seen
);

  localparam int FRAC = aisr_pkg::FRAC_DEF;
  localparam logic [127:0] QUOT_CAP = 128'h100_0000_0000;

  aisr_pkg::out_item_t inverse_q[$];

  function automatic aisr_pkg::word_t round_quotient(bit neg, logic [127:0] mag, int k,
                                                     logic [127:0] den);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] r;
    num = mag << k;
    q = num / den;
    r = num % den;
    if (q > QUOT_CAP) q = QUOT_CAP;
    if (r >= den - r) q = q + 1;
    if (!neg) return (q > 128'h7FFF_FFFF) ? aisr_pkg::POS_LIMIT : aisr_pkg::word_t'(q);
    if (q >= 128'h8000_0000) return aisr_pkg::NEG_LIMIT;
    return aisr_pkg::word_t'(~q[31:0] + 32'd1);
  endfunction

  function automatic aisr_pkg::out_item_t invert_transform(aisr_pkg::in_item_t x);
    logic [11:0][31:0] src;
    logic [11:0][31:0] dst;
    logic [127:0] tmag[3];
    bit tneg[3];
    logic [127:0] amag[3];
    bit aneg[3];
    logic [127:0] len2;
    logic [127:0] psum;
    logic [127:0] nsum;
    logic [31:0] w;
    bit dneg;
    src = x;
    for (int j = 0; j < 3; j++) begin
      w = src[11 - 9 - j];
      tneg[j] = w[31];
      tmag[j] = w[31] ? 128'(33'h1_0000_0000 - {1'b0, w}) : 128'(w);
    end
    for (int i = 0; i < 3; i++) begin
      len2 = 0;
      psum = 0;
      nsum = 0;
      for (int j = 0; j < 3; j++) begin
        w = src[11 - 3 * i - j];
        aneg[j] = w[31];
        amag[j] = w[31] ? 128'(33'h1_0000_0000 - {1'b0, w}) : 128'(w);
        len2 = len2 + amag[j] * amag[j];
        if (aneg[j] != tneg[j]) nsum = nsum + amag[j] * tmag[j];
        else psum = psum + amag[j] * tmag[j];
      end
      if (len2 == 0) begin
        for (int j = 0; j < 3; j++) dst[11 - 3 * i - j] = aisr_pkg::POS_LIMIT;
        dst[11 - 9 - i] = aisr_pkg::POS_LIMIT;
      end else begin
        for (int j = 0; j < 3; j++)
          dst[11 - 3 * i - j] = round_quotient(aneg[j], amag[j], 2 * FRAC, len2);
        dneg = nsum > psum;
        dst[11 - 9 - i] = round_quotient(!dneg, dneg ? nsum - psum : psum - nsum,
                                         FRAC, len2);
      end
    end
    return aisr_pkg::out_item_t'(dst);
  endfunction

  always @(posedge clk) begin
    logic [11:0][31:0] want;
    logic [11:0][31:0] got;
    aisr_pkg::out_item_t head;
    int errs;
    errs = 0;
    if (!rst_n) begin
      inverse_q.delete();
      fail_count <= 0;
      pending <= 0;
      results_seen <= 0;
      saturated_seen <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) inverse_q.push_back(invert_transform(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        got = out_ch.data;
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errs = 1;
        end else begin
          head = inverse_q.pop_front();
          want = head;
          for (int f = 0; f < 12; f++)
            if (got[11 - f] == aisr_pkg::POS_LIMIT || got[11 - f] == aisr_pkg::NEG_LIMIT) begin
              saturated_seen <= saturated_seen + 1;
              break;
            end
          for (int f = 0; f < 12; f++)
            if (got[11 - f] !== want[11 - f]) begin
              $display("%0t: field %0d expected %h actual %h", $time, f,
                       want[11 - f], got[11 - f]);
              errs = errs + 1;
            end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      pending <= inverse_q.size();
    end
  end

endmodule

>>> bench/affine_inverse_scaled_rotation_test.sv
// Testbench top: drives transforms into the block and gives the verdict.
`timescale 1ns / 1ps
module affine_inverse_scaled_rotation_test;

  localparam int ONE = 1 << aisr_pkg::FRAC_DEF;
  localparam int LATENCY = 38;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   results_seen;
  int   saturated_seen;
  int   cycles = 0;
  int   items_sent = 0;
  bit   calm = 1'b0;
  bit   tail = 1'b0;
  int   stall_left = 0;

  aisr_in_if  in_ch();
  aisr_out_if out_ch();

  affine_inverse_scaled_rotation u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  aisr_scoreboard u_scoreboard (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_seen   (results_seen),
    .saturated_seen (saturated_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("affine_inverse_scaled_rotation_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!tail && !calm && $urandom_range(0, 7) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] scale_word();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic aisr_pkg::in_item_t diag(logic [31:0] s0, logic [31:0] s1,
                                              logic [31:0] s2, logic [31:0] tx,
                                              logic [31:0] ty, logic [31:0] tz);
    logic [11:0][31:0] w;
    w = '{s0, 0, 0, 0, s1, 0, 0, 0, s2, tx, ty, tz};
    return aisr_pkg::in_item_t'(w);
  endfunction

  function automatic aisr_pkg::in_item_t random_transform();
    logic [11:0][31:0] w;
    int perm[3];
    int k;
    int mode;
    mode = $urandom_range(0, 99);
    perm = '{0, 1, 2};
    for (int i = 2; i > 0; i--) begin
      k = $urandom_range(0, i);
      {perm[i], perm[k]} = {perm[k], perm[i]};
    end
    for (int f = 0; f < 12; f++) begin
      if (mode < 70) w[11 - f] = (f < 9) ? 32'd0 : scale_word();
      else if (mode < 85) w[11 - f] = scale_word();
      else w[11 - f] = $urandom;
    end
    if (mode < 70)
      for (int i = 0; i < 3; i++)
        if ($urandom_range(0, 19) != 0) w[11 - 3 * i - perm[i]] = scale_word();
    return aisr_pkg::in_item_t'(w);
  endfunction

  task automatic send(aisr_pkg::in_item_t item);
    int gap;
    if (!tail && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  initial begin
    logic [11:0][31:0] w;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(aisr_pkg::in_item_t'('0));
    send(diag(ONE, ONE, ONE, 0, 0, 0));
    send(diag(ONE, 2 * ONE, ONE / 2, 3 * ONE, -5 * ONE, 7 * ONE));
    send(diag(-ONE, -ONE, -ONE, ONE, ONE, ONE));
    send(diag(1, -1, 2, ONE, -ONE, 0));
    send(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send(diag(ONE, 0, ONE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send(diag(0, ONE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send(diag(3, 3, 3, 1, 1, 1));
    send(diag(2, 2, 2, 1, -1, 1));
    send(diag(ONE, ONE, ONE, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    send(diag(256, -256, 16, 32'h8000_0000, 32'h7FFF_FFFF, -1));
    w = '{default: 32'h8000_0000};
    send(aisr_pkg::in_item_t'(w));
    w = '{default: 32'h7FFF_FFFF};
    send(aisr_pkg::in_item_t'(w));
    w = '{default: 32'hFFFF_FFFF};
    send(aisr_pkg::in_item_t'(w));
    w = '{ONE, ONE, 0, -ONE, ONE, 0, 0, 0, ONE, ONE, 2 * ONE, 3 * ONE};
    send(aisr_pkg::in_item_t'(w));
    w = '{1, 1, 1, 0, 0, 0, 1, -1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    send(aisr_pkg::in_item_t'(w));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 250 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        in_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      if (n == RANDOM_ITEMS - 200) tail = 1'b1;
      send(random_transform());
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d transforms, checked %0d inverses, %0d with a saturated field.",
             items_sent, results_seen, saturated_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("affine_inverse_scaled_rotation_test OK");
    end else begin
      $display("affine_inverse_scaled_rotation_test NOT OK");
    end
    $finish;
  end
endmodule
